// ===== rtl/scafifo_pkg.sv =====
// Shared types, constants and layout tables for the scancode-to-ASCII FIFO.
// No dependencies; scafifo_xlate and the top level import this package.
package scafifo_pkg;

   // Character buffer geometry
   localparam int BufferDepth = 256;
   localparam int PtrWidth    = $clog2(BufferDepth);
   localparam int CharWidth   = 7;
   localparam int CodeWidth   = 8;

   // Request opcodes
   localparam logic OpScan = 1'b0;
   localparam logic OpRead = 1'b1;

   // Set-1 scancodes of interest
   localparam logic [CodeWidth-1:0] ScLShift  = 8'h2A;
   localparam logic [CodeWidth-1:0] ScRShift  = 8'h36;
   localparam logic [CodeWidth-1:0] ScRelease = 8'h80;

   // Layout tables cover make codes 0x00 to 0x39
   localparam int LayoutSize  = 58;
   localparam int LayoutIndex = $clog2(LayoutSize);

   localparam logic [CharWidth-1:0] PlainLayout [LayoutSize] = '{
      7'h00, 7'h00, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
      7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72,
      7'h74, 7'h79, 7'h75, 7'h69, 7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00,
      7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
      7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E,
      7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h00, 7'h00, 7'h20
   };

   localparam logic [CharWidth-1:0] ShiftedLayout [LayoutSize] = '{
      7'h00, 7'h00, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A,
      7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09, 7'h51, 7'h57, 7'h45, 7'h52,
      7'h54, 7'h59, 7'h55, 7'h49, 7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00,
      7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
      7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E,
      7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h00, 7'h00, 7'h20
   };

   // Decoder verdict on one scancode
   typedef struct packed {
      logic                 shift_make;
      logic                 shift_break;
      logic [CharWidth-1:0] ch;   // zero when the code yields no character
   } xlate_result_type;

endpackage

// ===== rtl/scafifo_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
module scafifo_ram #(
   parameter int Width = 8,
   parameter int Depth = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/scafifo_xlate.sv =====
// Scancode decoder: classifies shift make/break codes and looks up characters.
// Depends on scafifo_pkg for the layout tables and the result struct.
module scafifo_xlate (
   input  logic [scafifo_pkg::CodeWidth-1:0] scan_code,
   input  logic                              shift_held,
   output scafifo_pkg::xlate_result_type     result
);
   import scafifo_pkg::*;

   logic                   in_table;
   logic [LayoutIndex-1:0] index;
   logic [CharWidth-1:0]   plain_ch;
   logic [CharWidth-1:0]   shifted_ch;

   // Restrict lookups to make codes inside the table
   assign in_table = ((scan_code & ScRelease) == '0) &&
                     (scan_code < CodeWidth'(LayoutSize));
   assign index    = in_table ? scan_code[LayoutIndex-1:0] : '0;

   assign plain_ch   = PlainLayout[index];
   assign shifted_ch = ShiftedLayout[index];

   // Classify the code and pick the layout by shift state
   always_comb begin
      result.shift_make  = (scan_code == ScLShift) || (scan_code == ScRShift);
      result.shift_break = (scan_code == (ScLShift | ScRelease)) ||
                           (scan_code == (ScRShift | ScRelease));
      if (in_table && !result.shift_make) begin
         result.ch = shift_held ? shifted_ch : plain_ch;
      end else begin
         result.ch = '0;
      end
   end

endmodule

// ===== rtl/scancode_to_ascii_fifo.sv =====
// Top level of the set-1 scancode to ASCII translator with character FIFO.
// Depends on scafifo_pkg, scafifo_xlate and scafifo_ram.
//
// Usage:
//   Request channel: drive req_opcode and req_scan_code and raise start; the
//   beat is taken at a rising edge where start is high and busy is low.
//   busy stays low, so one beat can be taken every cycle.
//   Opcode scan feeds one raw scancode; opcode read pops the oldest character.
//   Response channel: every request beat yields one response beat, shown for
//   exactly one cycle with rsp_strobe high, in the cycle after the request.
//   The character comes from the registered read of the character RAM;
//   throughput is one beat per cycle.
//   The receiver cannot stall: each response beat is taken as it appears.
//   A full buffer (depth minus one characters) drops new characters and
//   flags rsp_char_dropped; a read from an empty buffer returns no character.
//   Reset clears the shift flag, the strobe and both pointers; the RAM is not cleared,
//   since an entry is only read after it has been written.
module scancode_to_ascii_fifo (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_opcode,
   input  logic [scafifo_pkg::CodeWidth-1:0]   req_scan_code,
   output logic                                rsp_strobe,
   output logic [scafifo_pkg::CharWidth-1:0]   rsp_ascii_char,
   output logic                                rsp_char_valid,
   output logic                                rsp_buffer_not_empty,
   output logic                                rsp_char_dropped
);
   import scafifo_pkg::*;

   logic                  accept;
   xlate_result_type      xlate;

   logic                  shift_ff,     shift_in;
   logic [PtrWidth-1:0]   wr_ptr_ff,    wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff,    rd_ptr_in;
   logic                  strobe_ff,    strobe_in;
   logic                  valid_ff,     valid_in;
   logic                  not_empty_ff, not_empty_in;
   logic                  dropped_ff,   dropped_in;

   logic [PtrWidth-1:0]   wr_ptr_next;
   logic [PtrWidth-1:0]   rd_ptr_next;
   logic                  ram_wr_en;
   logic                  ram_rd_en;
   logic [CharWidth-1:0]  ram_rd_data;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   // Decode the incoming scancode against the current shift state
   scafifo_xlate u_xlate (
      .scan_code  (req_scan_code),
      .shift_held (shift_ff),
      .result     (xlate)
   );

   // Advance pointers with wrap at the buffer depth
   assign wr_ptr_next = (wr_ptr_ff == PtrWidth'(BufferDepth - 1)) ?
                        '0 : wr_ptr_ff + PtrWidth'(1);
   assign rd_ptr_next = (rd_ptr_ff == PtrWidth'(BufferDepth - 1)) ?
                        '0 : rd_ptr_ff + PtrWidth'(1);

   // Update shift state, pointers and response flags for one beat
   always_comb begin
      shift_in   = shift_ff;
      wr_ptr_in  = wr_ptr_ff;
      rd_ptr_in  = rd_ptr_ff;
      ram_wr_en  = 1'b0;
      ram_rd_en  = 1'b0;
      valid_in   = 1'b0;
      dropped_in = 1'b0;
      strobe_in  = accept;
      if (accept) begin
         if (req_opcode == OpRead) begin
            if (wr_ptr_ff != rd_ptr_ff) begin
               ram_rd_en = 1'b1;
               valid_in  = 1'b1;
               rd_ptr_in = rd_ptr_next;
            end
         end else if (xlate.shift_make) begin
            shift_in = 1'b1;
         end else if (xlate.shift_break) begin
            shift_in = 1'b0;
         end else if (xlate.ch != '0) begin
            if (wr_ptr_next != rd_ptr_ff) begin
               ram_wr_en = 1'b1;
               wr_ptr_in = wr_ptr_next;
            end else begin
               dropped_in = 1'b1;
            end
         end
      end
      not_empty_in = (wr_ptr_in != rd_ptr_in);
   end

   // Character store
   scafifo_ram #(
      .Width (CharWidth),
      .Depth (BufferDepth)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (wr_ptr_ff),
      .wr_data (xlate.ch),
      .rd_en   (ram_rd_en),
      .rd_addr (rd_ptr_ff),
      .rd_data (ram_rd_data)
   );

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff  <= 1'b0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         strobe_ff <= 1'b0;
      end else begin
         shift_ff  <= shift_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         strobe_ff <= strobe_in;
      end
   end

   // Hold response flags for the beat
   always_ff @(posedge clock) begin
      valid_ff     <= valid_in;
      not_empty_ff <= not_empty_in;
      dropped_ff   <= dropped_in;
   end

   // Drive the response beat; the character comes straight from the RAM
   assign rsp_strobe           = strobe_ff;
   assign rsp_char_valid       = valid_ff;
   assign rsp_ascii_char       = valid_ff ? ram_rd_data : '0;
   assign rsp_buffer_not_empty = not_empty_ff;
   assign rsp_char_dropped     = dropped_ff;

endmodule

// ===== test/scancode_to_ascii_fifo_test.sv =====
`timescale 1ns / 100ps
// Testbench for scancode_to_ascii_fifo: translation, shift tracking and the character FIFO.
// Depends on scafifo_pkg and the RTL of the block; a scoreboard class predicts every response.
module scancode_to_ascii_fifo_test;
   import scafifo_pkg::*;

   localparam int ClockPeriod = 20;
   localparam int RandomBeats = 1800;
   localparam int RunLimit    = 1_000_000;   // cycles

   // US layout, unshifted and shifted, indexed by make code
   localparam logic [CharWidth-1:0] PlainKeys [LayoutSize] = '{
      7'h00, 7'h00, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
      7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72,
      7'h74, 7'h79, 7'h75, 7'h69, 7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00,
      7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
      7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E,
      7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h00, 7'h00, 7'h20
   };
   localparam logic [CharWidth-1:0] ShiftedKeys [LayoutSize] = '{
      7'h00, 7'h00, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A,
      7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09, 7'h51, 7'h57, 7'h45, 7'h52,
      7'h54, 7'h59, 7'h55, 7'h49, 7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00,
      7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
      7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E,
      7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h00, 7'h00, 7'h20
   };

   typedef struct packed {
      logic [CharWidth-1:0] ch;
      logic                 valid;
      logic                 not_empty;
      logic                 dropped;
   } key_beat_type;

   typedef enum {PhaseFill, PhaseDrain, PhaseMixed} traffic_phase_type;

   // Tracks shift state and buffered characters; predicts each response beat
   class keymap_scoreboard;
      bit                   shift_held;
      logic [CharWidth-1:0] chars[$];
      key_beat_type         pending[$];
      int errors, popped, drops, empty_reads, beats;

      function void note_request(logic op, logic [CodeWidth-1:0] code);
         key_beat_type         beat = '0;
         logic [CharWidth-1:0] c;
         beats++;
         if (op == OpRead) begin
            if (chars.size() > 0) begin
               beat.ch    = chars.pop_front();
               beat.valid = 1'b1;
               popped++;
            end else begin
               empty_reads++;
            end
         end else if (code == ScLShift || code == ScRShift) begin
            shift_held = 1'b1;
         end else if (code == (ScLShift | ScRelease) || code == (ScRShift | ScRelease)) begin
            shift_held = 1'b0;
         end else if (!code[7] && code < LayoutSize) begin
            c = shift_held ? ShiftedKeys[code] : PlainKeys[code];
            if (c != '0) begin
               // one slot always stays free, so depth minus one characters fit
               if (chars.size() < BufferDepth - 1) begin
                  chars.push_back(c);
               end else begin
                  beat.dropped = 1'b1;
                  drops++;
               end
            end
         end
         beat.not_empty = (chars.size() != 0);
         pending.push_back(beat);
      endfunction

      function void check_response(key_beat_type got);
         key_beat_type want;
         if (pending.size() == 0) begin
            $display("%0t: response beat with nothing outstanding: char %h valid %b",
                     $time, got.ch, got.valid);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (got !== want) begin
            $display("%0t: mismatch expected char %h valid %b not_empty %b dropped %b",
                     $time, want.ch, want.valid, want.not_empty, want.dropped);
            $display("%0t:          actual   char %h valid %b not_empty %b dropped %b",
                     $time, got.ch, got.valid, got.not_empty, got.dropped);
            errors++;
         end
      endfunction
   endclass

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   logic                 req_opcode;
   logic [CodeWidth-1:0] req_scan_code;
   logic                 rsp_strobe;
   logic [CharWidth-1:0] rsp_ascii_char;
   logic                 rsp_char_valid;
   logic                 rsp_buffer_not_empty;
   logic                 rsp_char_dropped;

   keymap_scoreboard sb = new();
   bit               quiet;
   int               counted;

   scancode_to_ascii_fifo i_dut (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_opcode           (req_opcode),
      .req_scan_code        (req_scan_code),
      .rsp_strobe           (rsp_strobe),
      .rsp_ascii_char       (rsp_ascii_char),
      .rsp_char_valid       (rsp_char_valid),
      .rsp_buffer_not_empty (rsp_buffer_not_empty),
      .rsp_char_dropped     (rsp_char_dropped)
   );

   initial begin
      clock = 1'b0;
      forever #(ClockPeriod / 2) clock = ~clock;
   end

   // Observe both channels on the same edge the block does
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe) begin
            sb.check_response(key_beat_type'{rsp_ascii_char, rsp_char_valid,
                                             rsp_buffer_not_empty, rsp_char_dropped});
         end
         if (start && !busy) begin
            sb.note_request(req_opcode, req_scan_code);
         end
      end
   end

   // Mostly back to back, some short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 60) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Hold the beat until taken, then idle for a random gap
   task automatic issue(logic op, logic [CodeWidth-1:0] code);
      int gap;
      start         <= 1'b1;
      req_opcode    <= op;
      req_scan_code <= code;
      do @(posedge clock); while (busy !== 1'b0);
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Draw one random beat shaped by the current traffic phase
   task automatic random_beat(traffic_phase_type phase);
      int                   r;
      int                   make_top, shift_top, noise_top;
      logic                 op;
      logic [CodeWidth-1:0] code;
      r = $urandom_range(0, 99);
      case (phase)
         PhaseFill:  begin make_top = 78; shift_top = 89; noise_top = 95; end
         PhaseDrain: begin make_top = -1; shift_top = -1; noise_top = 12; end
         default:    begin make_top = 35; shift_top = 45; noise_top = 55; end
      endcase
      op   = OpScan;
      code = CodeWidth'($urandom_range(0, 255));
      if (r <= make_top) begin
         code = CodeWidth'($urandom_range(2, LayoutSize - 1));
      end else if (r <= shift_top) begin
         code = $urandom_range(0, 1) ? ScLShift : ScRShift;
         if ($urandom_range(0, 1)) code = code | ScRelease;
      end else if (r > noise_top) begin
         op = OpRead;
      end
      // in the drain phase a few make codes keep the buffer from sitting empty
      if (phase == PhaseDrain && r < 6) code = CodeWidth'($urandom_range(2, LayoutSize - 1));
      counted++;
      issue(op, code);
   endtask

   initial begin
      #(longint'(RunLimit) * ClockPeriod);
      $display("simulation failed");
      $finish;
   end

   initial begin
      traffic_phase_type phase;
      int                left;
      reset         = 1'b1;
      start         = 1'b0;
      req_opcode    = OpScan;
      req_scan_code = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty read, dead table entries, both shifts, releases, out of range
      issue(OpRead, 8'hFF);
      issue(OpScan, 8'h00);
      issue(OpScan, 8'h01);
      issue(OpScan, 8'h02);
      issue(OpScan, ScLShift);
      issue(OpScan, 8'h02);
      issue(OpScan, 8'h39);
      issue(OpScan, ScLShift | ScRelease);
      issue(OpScan, ScRShift);
      issue(OpScan, 8'h1E);
      issue(OpRead, ScRShift | ScRelease);
      issue(OpScan, ScRShift | ScRelease);
      issue(OpScan, 8'h1E);
      issue(OpScan, 8'h3A);
      issue(OpScan, 8'h7F);
      issue(OpScan, 8'h9E);
      issue(OpScan, 8'hFF);
      issue(OpScan, 8'h1D);
      issue(OpScan, 8'h37);
      issue(OpScan, 8'h38);
      issue(OpScan, 8'h35);
      repeat (5) issue(OpRead, 8'h00);
      issue(OpRead, ScLShift);

      // Random: fill past capacity, drain past empty, then interleave
      phase = PhaseFill;
      while (counted < RandomBeats) begin
         quiet = ($urandom_range(0, 3) == 0);
         left  = (phase == PhaseFill) ? 350 : (phase == PhaseDrain) ? 300 : 200;
         repeat (left) begin
            if (counted < RandomBeats) random_beat(phase);
         end
         case (phase)
            PhaseFill:  phase = PhaseDrain;
            PhaseDrain: phase = PhaseMixed;
            default:    phase = PhaseFill;
         endcase
      end
      start <= 1'b0;

      // Drain outstanding responses, then let the last response settle
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);

      $display("Ran %0d request beats: %0d characters read back, %0d dropped on a full buffer,",
               sb.beats, sb.popped, sb.drops);
      $display("%0d reads of an empty buffer, %0d mismatches.", sb.empty_reads, sb.errors);
      if (sb.errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
